>>> hdl/hwfq_pkg.sv
// ----------------------------------------------------------------------------
// hwfq_pkg: shared types and constants for the weak form quadrature block
// Item and queue structs, config register codes, the micro-op set and the
// micro-program that evaluates the residual and Jacobian integrands.
// ----------------------------------------------------------------------------
package hwfq_pkg;

  localparam int PC_W        = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  // Program entry points
  localparam logic [PC_W-1:0] PC_RES_EULER = 6'd0;
  localparam logic [PC_W-1:0] PC_RES_CN    = 6'd12;
  localparam logic [PC_W-1:0] PC_JAC       = 6'd32;

  localparam logic        RST_TIME_SCHEME = 1'b1;
  localparam logic        RST_FORM_KIND   = 1'b0;
  localparam logic [47:0] RST_CAP         = 48'd131072000000;
  localparam logic [31:0] RST_BASE        = 32'd655360;
  localparam logic [31:0] RST_SLOPE       = 32'd6554;

  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN = {1'b1, 63'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_SCHEME = 3'd0,
    CFG_FORM_KIND   = 3'd1,
    CFG_CAP         = 3'd2,
    CFG_BASE        = 3'd3,
    CFG_SLOPE       = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_MULQ,   // product shifted right by the fraction bits
    OP_MUL0,   // product kept at full fraction
    OP_ADD,
    OP_ADDH,   // second operand halved under Crank-Nicolson
    OP_ACC     // add into accumulator, retire the item
  } op_t;

  typedef enum logic [4:0] {
    SRC_W, SRC_TI, SRC_TIX, SRC_TIY, SRC_OV, SRC_OX, SRC_OY,
    SRC_VV, SRC_VX, SRC_VY, SRC_DIFF, SRC_CAP, SRC_BASE, SRC_SLOPE,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t dst;
    src_t a;
    src_t b;
  } uop_t;

  typedef struct packed {
    logic        cn;
    logic        form;
    logic [47:0] cap;
    logic [31:0] base;
    logic [31:0] slope;
  } cfg_t;

  typedef struct packed {
    logic [30:0]        weight;
    logic signed [31:0] ti;
    logic signed [31:0] tix;
    logic signed [31:0] tiy;
    logic signed [31:0] ov;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] vv;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [32:0] diff;
    logic               last;
    logic [PC_W-1:0]    pc;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    item_t head;
  } q_rd_t;

  typedef struct packed {
    logic               clip;
    logic signed [63:0] val;
  } sat_t;

  typedef struct packed {
    logic               start;
    logic               shift;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    sat_t res;
  } mul_rsp_t;

  function automatic uop_t mk(input op_t op, input src_t dst, input src_t a, input src_t b);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t r;
    case (pc)
      // residual, implicit Euler
      6'd0:  r = mk(OP_MULQ, SRC_T0, SRC_TI,    SRC_TI);
      6'd1:  r = mk(OP_MULQ, SRC_T0, SRC_SLOPE, SRC_T0);
      6'd2:  r = mk(OP_ADD,  SRC_T0, SRC_BASE,  SRC_T0);
      6'd3:  r = mk(OP_MULQ, SRC_T1, SRC_TIX,   SRC_VX);
      6'd4:  r = mk(OP_MULQ, SRC_T2, SRC_TIY,   SRC_VY);
      6'd5:  r = mk(OP_ADD,  SRC_T1, SRC_T1,    SRC_T2);
      6'd6:  r = mk(OP_MULQ, SRC_T0, SRC_T0,    SRC_T1);
      6'd7:  r = mk(OP_MULQ, SRC_T1, SRC_CAP,   SRC_DIFF);
      6'd8:  r = mk(OP_MULQ, SRC_T1, SRC_T1,    SRC_VV);
      6'd9:  r = mk(OP_ADDH, SRC_T1, SRC_T1,    SRC_T0);
      6'd10: r = mk(OP_MUL0, SRC_T1, SRC_W,     SRC_T1);
      6'd11: r = mk(OP_ACC,  SRC_T0, SRC_T1,    SRC_T0);
      // residual, Crank-Nicolson
      6'd12: r = mk(OP_MULQ, SRC_T0, SRC_TI,    SRC_TI);
      6'd13: r = mk(OP_MULQ, SRC_T0, SRC_SLOPE, SRC_T0);
      6'd14: r = mk(OP_ADD,  SRC_T0, SRC_BASE,  SRC_T0);
      6'd15: r = mk(OP_MULQ, SRC_T1, SRC_TIX,   SRC_VX);
      6'd16: r = mk(OP_MULQ, SRC_T2, SRC_TIY,   SRC_VY);
      6'd17: r = mk(OP_ADD,  SRC_T1, SRC_T1,    SRC_T2);
      6'd18: r = mk(OP_MULQ, SRC_T0, SRC_T0,    SRC_T1);
      6'd19: r = mk(OP_MULQ, SRC_T1, SRC_OV,    SRC_OV);
      6'd20: r = mk(OP_MULQ, SRC_T1, SRC_SLOPE, SRC_T1);
      6'd21: r = mk(OP_ADD,  SRC_T1, SRC_BASE,  SRC_T1);
      6'd22: r = mk(OP_MULQ, SRC_T2, SRC_OX,    SRC_VX);
      6'd23: r = mk(OP_MULQ, SRC_T3, SRC_OY,    SRC_VY);
      6'd24: r = mk(OP_ADD,  SRC_T2, SRC_T2,    SRC_T3);
      6'd25: r = mk(OP_MULQ, SRC_T1, SRC_T1,    SRC_T2);
      6'd26: r = mk(OP_MULQ, SRC_T2, SRC_CAP,   SRC_DIFF);
      6'd27: r = mk(OP_MULQ, SRC_T2, SRC_T2,    SRC_VV);
      6'd28: r = mk(OP_ADDH, SRC_T2, SRC_T2,    SRC_T0);
      6'd29: r = mk(OP_ADDH, SRC_T2, SRC_T2,    SRC_T1);
      6'd30: r = mk(OP_MUL0, SRC_T2, SRC_W,     SRC_T2);
      6'd31: r = mk(OP_ACC,  SRC_T0, SRC_T2,    SRC_T0);
      // Jacobian
      6'd32: r = mk(OP_MULQ, SRC_T0, SRC_TI,    SRC_TI);
      6'd33: r = mk(OP_MULQ, SRC_T0, SRC_SLOPE, SRC_T0);
      6'd34: r = mk(OP_ADD,  SRC_T0, SRC_BASE,  SRC_T0);
      6'd35: r = mk(OP_MULQ, SRC_T1, SRC_TIX,   SRC_VX);
      6'd36: r = mk(OP_MULQ, SRC_T2, SRC_TIY,   SRC_VY);
      6'd37: r = mk(OP_ADD,  SRC_T1, SRC_T1,    SRC_T2);
      6'd38: r = mk(OP_MULQ, SRC_T2, SRC_SLOPE, SRC_TI);
      6'd39: r = mk(OP_ADD,  SRC_T2, SRC_T2,    SRC_T2);
      6'd40: r = mk(OP_MULQ, SRC_T2, SRC_T2,    SRC_OV);
      6'd41: r = mk(OP_MULQ, SRC_T2, SRC_T2,    SRC_T1);
      6'd42: r = mk(OP_MULQ, SRC_T1, SRC_OX,    SRC_VX);
      6'd43: r = mk(OP_MULQ, SRC_T3, SRC_OY,    SRC_VY);
      6'd44: r = mk(OP_ADD,  SRC_T1, SRC_T1,    SRC_T3);
      6'd45: r = mk(OP_MULQ, SRC_T0, SRC_T0,    SRC_T1);
      6'd46: r = mk(OP_MULQ, SRC_T1, SRC_CAP,   SRC_OV);
      6'd47: r = mk(OP_MULQ, SRC_T1, SRC_T1,    SRC_VV);
      6'd48: r = mk(OP_ADDH, SRC_T1, SRC_T1,    SRC_T2);
      6'd49: r = mk(OP_ADDH, SRC_T1, SRC_T1,    SRC_T0);
      6'd50: r = mk(OP_MUL0, SRC_T1, SRC_W,     SRC_T1);
      6'd51: r = mk(OP_ACC,  SRC_T0, SRC_T1,    SRC_T0);
      default: r = mk(OP_ACC, SRC_T0, SRC_T0, SRC_T0);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/heat_weak_form_quadrature.sv
// ----------------------------------------------------------------------------
// heat_weak_form_quadrature: weak form quadrature sum for nonlinear heat
// Accumulates weight times the residual or Jacobian integrand over the
// quadrature points of one element and emits the saturated sum.
// ----------------------------------------------------------------------------
// Each accepted point is evaluated by a micro-sequencer that drives one shared
// signed 64x64 multiplier, built from four 32x32 partial products plus a
// rounding and saturation step, and does its saturating adds itself. A
// two-entry queue sits in front of the evaluator, so points keep being
// accepted while the queue has room and earlier ones are worked on. On a
// point marked last, the sum and the clip flag go to an output register and
// the sum starts over from zero; if that register still holds an unread
// result, the evaluator holds until it is taken. Write configuration only
// when the block is idle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module heat_weak_form_quadrature #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hwfq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hwfq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [30:0]                         weight,
  input  logic signed [31:0]                  iter_val,
  input  logic signed [31:0]                  iter_dx,
  input  logic signed [31:0]                  iter_dy,
  input  logic signed [31:0]                  other_val,
  input  logic signed [31:0]                  other_dx,
  input  logic signed [31:0]                  other_dy,
  input  logic signed [31:0]                  test_val,
  input  logic signed [31:0]                  test_dx,
  input  logic signed [31:0]                  test_dy,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [63:0]                  integral,
  output logic                                saturated
);

  hwfq_pkg::cfg_t     cfg;
  hwfq_pkg::q_wr_t    q_wr;
  hwfq_pkg::q_rd_t    q_rd;
  hwfq_pkg::mul_req_t mul_req;
  hwfq_pkg::mul_rsp_t mul_rsp;
  logic               q_full;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cn    <= hwfq_pkg::RST_TIME_SCHEME;
      cfg.form  <= hwfq_pkg::RST_FORM_KIND;
      cfg.cap   <= hwfq_pkg::RST_CAP;
      cfg.base  <= hwfq_pkg::RST_BASE;
      cfg.slope <= hwfq_pkg::RST_SLOPE;
    end else if (cfg_we) begin
      case (hwfq_pkg::cfg_idx_t'(cfg_index))
        hwfq_pkg::CFG_TIME_SCHEME: cfg.cn    <= cfg_data[0];
        hwfq_pkg::CFG_FORM_KIND:   cfg.form  <= cfg_data[0];
        hwfq_pkg::CFG_CAP:         cfg.cap   <= cfg_data[47:0];
        hwfq_pkg::CFG_BASE:        cfg.base  <= cfg_data[31:0];
        hwfq_pkg::CFG_SLOPE:       cfg.slope <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  hwfq_front u_front (
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .weight     (weight),
    .iter_val   (iter_val),
    .iter_dx    (iter_dx),
    .iter_dy    (iter_dy),
    .other_val  (other_val),
    .other_dx   (other_dx),
    .other_dy   (other_dy),
    .test_val   (test_val),
    .test_dx    (test_dx),
    .test_dy    (test_dy),
    .last_point (last_point),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  hwfq_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (q_pop),
    .q_rd (q_rd),
    .full (q_full)
  );

  hwfq_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  hwfq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .integral  (integral),
    .saturated (saturated)
  );

endmodule

>>> hdl/hwfq_front.sv
// ----------------------------------------------------------------------------
// hwfq_front: point intake
// Accepts quadrature points, picks the micro-program for the current form
// and time scheme, forms the value difference and pushes into the queue.
// ----------------------------------------------------------------------------
module hwfq_front (
  input  hwfq_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        weight,
  input  logic signed [31:0] iter_val,
  input  logic signed [31:0] iter_dx,
  input  logic signed [31:0] iter_dy,
  input  logic signed [31:0] other_val,
  input  logic signed [31:0] other_dx,
  input  logic signed [31:0] other_dy,
  input  logic signed [31:0] test_val,
  input  logic signed [31:0] test_dx,
  input  logic signed [31:0] test_dy,
  input  logic               last_point,
  input  logic               q_full,
  output hwfq_pkg::q_wr_t    q_wr
);

  logic [hwfq_pkg::PC_W-1:0] start_pc;

  always_comb begin
    if (cfg.form) begin
      start_pc = hwfq_pkg::PC_JAC;
    end else if (cfg.cn) begin
      start_pc = hwfq_pkg::PC_RES_CN;
    end else begin
      start_pc = hwfq_pkg::PC_RES_EULER;
    end
  end

  assign in_stall = q_full;

  always_comb begin
    q_wr.push        = in_valid & ~q_full;
    q_wr.item.weight = weight;
    q_wr.item.ti     = iter_val;
    q_wr.item.tix    = iter_dx;
    q_wr.item.tiy    = iter_dy;
    q_wr.item.ov     = other_val;
    q_wr.item.ox     = other_dx;
    q_wr.item.oy     = other_dy;
    q_wr.item.vv     = test_val;
    q_wr.item.vx     = test_dx;
    q_wr.item.vy     = test_dy;
    // fits in 33 bits, never clips
    q_wr.item.diff   = {iter_val[31], iter_val} - {other_val[31], other_val};
    q_wr.item.last   = last_point;
    q_wr.item.pc     = start_pc;
  end

endmodule

>>> hdl/hwfq_queue.sv
// ----------------------------------------------------------------------------
// hwfq_queue: point queue
// Short FIFO between intake and evaluation; the head stays put until the
// evaluator retires it.
// ----------------------------------------------------------------------------
module hwfq_queue (
  input  logic              clk,
  input  logic              rst,
  input  hwfq_pkg::q_wr_t   q_wr,
  input  logic              pop,
  output hwfq_pkg::q_rd_t   q_rd,
  output logic              full
);

  localparam int DEPTH = hwfq_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hwfq_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign q_rd.empty = (count == '0);
  assign q_rd.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (q_wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !q_wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");
`endif

endmodule

>>> hdl/hwfq_mul.sv
// ----------------------------------------------------------------------------
// hwfq_mul: shared saturating multiplier
// Signed 64x64 product built from four 32x32 partial products, then shifted
// by the fraction bits with rounding toward minus infinity and saturated.
// ----------------------------------------------------------------------------
module hwfq_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  hwfq_pkg::mul_req_t req,
  output hwfq_pkg::mul_rsp_t rsp
);

  localparam logic [2:0]   STEP_LAST_PP  = 3'd3;
  localparam logic [2:0]   STEP_LAST_ADD = 3'd4;
  localparam logic [2:0]   STEP_FINISH   = 3'd5;
  localparam logic [127:0] REM_MASK      = (128'd1 << FRAC_BITS) - 128'd1;

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic         shen;
  logic         busy;
  logic [2:0]   step;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] prod;
  logic         done_r;
  hwfq_pkg::sat_t res_r;

  logic [31:0]  a_word;
  logic [31:0]  b_word;
  logic [127:0] pp_shifted;
  logic [127:0] q;
  logic [127:0] qr;
  logic         rem;
  hwfq_pkg::sat_t fin;

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_word = step[1] ? ua[63:32] : ua[31:0];
  assign b_word = step[0] ? ub[63:32] : ub[31:0];

  always_comb begin
    case (pp_pos)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  always_comb begin
    q   = shen ? (prod >> FRAC_BITS) : prod;
    rem = shen & (|(prod & REM_MASK));
    qr  = q + {127'd0, rem};
    if (!neg) begin
      fin.clip = |q[127:63];
      fin.val  = fin.clip ? hwfq_pkg::SAT_MAX : q[63:0];
    end else begin
      fin.clip = (|qr[127:64]) | (qr[63] & (|qr[62:0]));
      fin.val  = fin.clip ? hwfq_pkg::SAT_MIN : -qr[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      step   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_FINISH) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua   <= req.a[63] ? -req.a : req.a;
      ub   <= req.b[63] ? -req.b : req.b;
      neg  <= req.a[63] ^ req.b[63];
      shen <= req.shift;
      prod <= '0;
    end else if (busy) begin
      if (step <= STEP_LAST_PP) begin
        pp     <= a_word * b_word;
        pp_pos <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      if (step != '0 && step <= STEP_LAST_ADD) begin
        prod <= prod + pp_shifted;
      end
      if (step == STEP_FINISH) begin
        res_r <= fin;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

>>> hdl/hwfq_back.sv
// ----------------------------------------------------------------------------
// hwfq_back: integrand evaluator and accumulator
// Steps through the micro-program of the queue head, one shared multiply or
// saturating add at a time, then adds weight times integrand into the sum.
// ----------------------------------------------------------------------------
module hwfq_back (
  input  logic               clk,
  input  logic               rst,
  input  hwfq_pkg::cfg_t     cfg,
  input  hwfq_pkg::q_rd_t    q_rd,
  output logic               q_pop,
  output hwfq_pkg::mul_req_t mul_req,
  input  hwfq_pkg::mul_rsp_t mul_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] integral,
  output logic               saturated
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_MULW = 3'b100
  } state_t;

  state_t                    state;
  logic [hwfq_pkg::PC_W-1:0] pc;
  logic signed [63:0]        t0;
  logic signed [63:0]        t1;
  logic signed [63:0]        t2;
  logic signed [63:0]        t3;
  logic signed [63:0]        acc;
  logic                      clip;

  hwfq_pkg::uop_t     uop;
  hwfq_pkg::item_t    it;
  logic signed [63:0] op_a;
  logic signed [63:0] op_b;
  logic signed [63:0] addend;
  hwfq_pkg::sat_t     add_res;
  hwfq_pkg::sat_t     acc_res;
  hwfq_pkg::sat_t     wr_res;
  logic               is_mul;
  logic               is_add;
  logic               is_acc;
  logic               out_free;
  logic               emit;
  logic               tmp_we;

  function automatic hwfq_pkg::sat_t add_sat(input logic signed [63:0] x,
                                             input logic signed [63:0] y);
    logic signed [64:0] s;
    hwfq_pkg::sat_t     r;
    s = {x[63], x} + {y[63], y};
    r.clip = s[64] ^ s[63];
    if (r.clip) begin
      r.val = s[64] ? hwfq_pkg::SAT_MIN : hwfq_pkg::SAT_MAX;
    end else begin
      r.val = s[63:0];
    end
    return r;
  endfunction

  assign uop = hwfq_pkg::uop_rom(pc);
  assign it  = q_rd.head;

  always_comb begin
    case (uop.a)
      hwfq_pkg::SRC_W:     op_a = {33'd0, it.weight};
      hwfq_pkg::SRC_TI:    op_a = {{32{it.ti[31]}}, it.ti};
      hwfq_pkg::SRC_TIX:   op_a = {{32{it.tix[31]}}, it.tix};
      hwfq_pkg::SRC_TIY:   op_a = {{32{it.tiy[31]}}, it.tiy};
      hwfq_pkg::SRC_OV:    op_a = {{32{it.ov[31]}}, it.ov};
      hwfq_pkg::SRC_OX:    op_a = {{32{it.ox[31]}}, it.ox};
      hwfq_pkg::SRC_OY:    op_a = {{32{it.oy[31]}}, it.oy};
      hwfq_pkg::SRC_VV:    op_a = {{32{it.vv[31]}}, it.vv};
      hwfq_pkg::SRC_VX:    op_a = {{32{it.vx[31]}}, it.vx};
      hwfq_pkg::SRC_VY:    op_a = {{32{it.vy[31]}}, it.vy};
      hwfq_pkg::SRC_DIFF:  op_a = {{31{it.diff[32]}}, it.diff};
      hwfq_pkg::SRC_CAP:   op_a = {16'd0, cfg.cap};
      hwfq_pkg::SRC_BASE:  op_a = {32'd0, cfg.base};
      hwfq_pkg::SRC_SLOPE: op_a = {32'd0, cfg.slope};
      hwfq_pkg::SRC_T0:    op_a = t0;
      hwfq_pkg::SRC_T1:    op_a = t1;
      hwfq_pkg::SRC_T2:    op_a = t2;
      hwfq_pkg::SRC_T3:    op_a = t3;
      default:             op_a = '0;
    endcase
  end

  always_comb begin
    case (uop.b)
      hwfq_pkg::SRC_W:     op_b = {33'd0, it.weight};
      hwfq_pkg::SRC_TI:    op_b = {{32{it.ti[31]}}, it.ti};
      hwfq_pkg::SRC_TIX:   op_b = {{32{it.tix[31]}}, it.tix};
      hwfq_pkg::SRC_TIY:   op_b = {{32{it.tiy[31]}}, it.tiy};
      hwfq_pkg::SRC_OV:    op_b = {{32{it.ov[31]}}, it.ov};
      hwfq_pkg::SRC_OX:    op_b = {{32{it.ox[31]}}, it.ox};
      hwfq_pkg::SRC_OY:    op_b = {{32{it.oy[31]}}, it.oy};
      hwfq_pkg::SRC_VV:    op_b = {{32{it.vv[31]}}, it.vv};
      hwfq_pkg::SRC_VX:    op_b = {{32{it.vx[31]}}, it.vx};
      hwfq_pkg::SRC_VY:    op_b = {{32{it.vy[31]}}, it.vy};
      hwfq_pkg::SRC_DIFF:  op_b = {{31{it.diff[32]}}, it.diff};
      hwfq_pkg::SRC_CAP:   op_b = {16'd0, cfg.cap};
      hwfq_pkg::SRC_BASE:  op_b = {32'd0, cfg.base};
      hwfq_pkg::SRC_SLOPE: op_b = {32'd0, cfg.slope};
      hwfq_pkg::SRC_T0:    op_b = t0;
      hwfq_pkg::SRC_T1:    op_b = t1;
      hwfq_pkg::SRC_T2:    op_b = t2;
      hwfq_pkg::SRC_T3:    op_b = t3;
      default:             op_b = '0;
    endcase
  end

  assign is_mul = (uop.op == hwfq_pkg::OP_MULQ) || (uop.op == hwfq_pkg::OP_MUL0);
  assign is_add = (uop.op == hwfq_pkg::OP_ADD) || (uop.op == hwfq_pkg::OP_ADDH);
  assign is_acc = (uop.op == hwfq_pkg::OP_ACC);

  // floor halving of conduction terms under Crank-Nicolson
  assign addend  = (uop.op == hwfq_pkg::OP_ADDH && cfg.cn) ? (op_b >>> 1) : op_b;
  assign add_res = add_sat(op_a, addend);
  assign acc_res = add_sat(acc, op_a);

  assign out_free = ~out_valid | ~out_stall;
  assign emit     = (state == S_EXEC) && is_acc && it.last && out_free;
  assign q_pop    = (state == S_EXEC) && is_acc && (~it.last | out_free);

  assign tmp_we = ((state == S_EXEC) && is_add) || ((state == S_MULW) && mul_rsp.done);
  assign wr_res = (state == S_MULW) ? mul_rsp.res : add_res;

  always_comb begin
    mul_req.start = (state == S_EXEC) && is_mul;
    mul_req.shift = (uop.op == hwfq_pkg::OP_MULQ);
    mul_req.a     = op_a;
    mul_req.b     = op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      acc       <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_rd.empty) begin
            pc    <= q_rd.head.pc;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_mul) begin
            state <= S_MULW;
          end else if (is_add) begin
            clip <= clip | add_res.clip;
            pc   <= pc + 1'b1;
          end else if (emit) begin
            out_valid <= 1'b1;
            acc       <= '0;
            clip      <= 1'b0;
            state     <= S_IDLE;
          end else if (q_pop) begin
            acc   <= acc_res.val;
            clip  <= clip | acc_res.clip;
            state <= S_IDLE;
          end
        end
        S_MULW: begin
          if (mul_rsp.done) begin
            clip  <= clip | mul_rsp.res.clip;
            pc    <= pc + 1'b1;
            state <= S_EXEC;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      integral  <= acc_res.val;
      saturated <= clip | acc_res.clip;
    end
    if (tmp_we) begin
      case (uop.dst)
        hwfq_pkg::SRC_T0: t0 <= wr_res.val;
        hwfq_pkg::SRC_T1: t1 <= wr_res.val;
        hwfq_pkg::SRC_T2: t2 <= wr_res.val;
        hwfq_pkg::SRC_T3: t3 <= wr_res.val;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_MULW))
    else $error("multiplier result arrived with no one waiting");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_rd.empty)
    else $error("evaluating with an empty queue");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && (acc == '0) && !clip))
    else $error("sum not cleared after emit");
`endif

endmodule
